// ===== sv/gri_pkg.sv =====
// gri_pkg: shared types, widths and constants of the gyro rate integrator.
// Used by every module under sv/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package gri_pkg;

	localparam int NUM_AXES   = 3;
	localparam int AXIS_YAW   = 0;
	localparam int AXIS_PITCH = 1;
	localparam int AXIS_ROLL  = 2;

	localparam int RATE_W  = 16;
	localparam int ANGLE_W = 23;
	localparam int MS_W    = 7;
	localparam int DB_W    = 15;
	localparam int CORR_W  = 17;
	localparam int ACC_W   = 25;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 72;

	typedef logic signed [RATE_W-1:0]  rate_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [MS_W-1:0]           ms_t;
	typedef logic [DB_W-1:0]           deadband_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	localparam ms_t       MAX_MS         = 7'd100;
	localparam deadband_t DEADBAND_RESET = 15'd160;

	localparam rate_t YAW_BIAS_RESET   = -16'sd464;
	localparam rate_t PITCH_BIAS_RESET = 16'sd144;
	localparam rate_t ROLL_BIAS_RESET  = 16'sd288;

	// angles in 1/16000 degree
	localparam acc_t HALF_TURN = 25'sd2880000;
	localparam acc_t FULL_TURN = 25'sd5760000;

	// per-stage load/advance strobes from the top level
	typedef struct packed {
		logic step1;
		logic load2;
		logic load3;
		logic step3;
		logic load5;
		logic step5;
	} pipe_ctl_t;

	typedef struct packed {
		logic                done;
		logic                busy;
		logic [NUM_AXES-1:0] neg;
	} calib_ctl_t;

endpackage

`default_nettype wire

// ===== sv/gri_calib.sv =====
// gri_calib: calibration run state (raw sums, sample count, active flag), stage 1.
// Emits the final sum magnitudes and signs when a run completes. Uses gri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gri_calib #(
	parameter int CALIB_SAMPLES = 100,
	localparam int SUM_W = gri_pkg::RATE_W + $clog2(CALIB_SAMPLES),
	localparam int CNT_W = $clog2(CALIB_SAMPLES + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gri_pkg::pipe_ctl_t    ctl,
	input  wire gri_pkg::rate_t        rate [gri_pkg::NUM_AXES],
	input  wire logic                  start,
	output gri_pkg::calib_ctl_t        cal,
	output logic [SUM_W-1:0]           mag [gri_pkg::NUM_AXES]
);

	localparam logic [CNT_W-1:0] N_CNT = CNT_W'(CALIB_SAMPLES);

	logic signed [SUM_W-1:0] sum_q [gri_pkg::NUM_AXES];
	logic signed [SUM_W-1:0] sum_new [gri_pkg::NUM_AXES];
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        cnt_new;
	logic                    active_q;
	logic                    fresh;
	logic                    active_eff;
	logic                    done;

	assign fresh      = start & ~active_q;
	assign active_eff = start | active_q;
	assign cnt_new    = (fresh ? '0 : cnt_q) + CNT_W'(1);
	assign done       = active_eff & (cnt_new >= N_CNT);

	always_comb begin
		for (int a = 0; a < gri_pkg::NUM_AXES; a++) begin
			sum_new[a] = (fresh ? '0 : sum_q[a]) + SUM_W'(rate[a]);
			mag[a]     = sum_new[a][SUM_W-1] ? SUM_W'(-sum_new[a]) : SUM_W'(sum_new[a]);
			cal.neg[a] = sum_new[a][SUM_W-1];
		end
		cal.done = done;
		cal.busy = active_eff & ~done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			for (int a = 0; a < gri_pkg::NUM_AXES; a++) begin
				sum_q[a] <= '0;
			end
		end else if (ctl.step1 && active_eff) begin
			if (done) begin
				active_q <= 1'b0;
				cnt_q    <= '0;
				for (int a = 0; a < gri_pkg::NUM_AXES; a++) begin
					sum_q[a] <= '0;
				end
			end else begin
				active_q <= 1'b1;
				cnt_q    <= cnt_new;
				for (int a = 0; a < gri_pkg::NUM_AXES; a++) begin
					sum_q[a] <= sum_new[a];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/gri_bias_div.sv =====
// gri_bias_div: divides the finished calibration sums by CALIB_SAMPLES (stages 2-3)
// with a reciprocal multiply and one correction step; holds the bias registers. Uses gri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gri_bias_div #(
	parameter int CALIB_SAMPLES = 100,
	localparam int SUM_W = gri_pkg::RATE_W + $clog2(CALIB_SAMPLES)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gri_pkg::pipe_ctl_t  ctl,
	input  wire gri_pkg::calib_ctl_t cal,
	input  wire logic [SUM_W-1:0] mag [gri_pkg::NUM_AXES],
	output gri_pkg::rate_t      bias [gri_pkg::NUM_AXES]
);

	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	// floor(2^SUM_W / N): estimate is exact or one low for any sum magnitude
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SUM_W) / CALIB_SAMPLES);
	localparam logic [SUM_W-1:0]   N_SUM = SUM_W'(CALIB_SAMPLES);

	logic [SUM_W-1:0]            mag_s2 [gri_pkg::NUM_AXES];
	logic [gri_pkg::NUM_AXES-1:0] neg_s2;
	logic                        done_s2;
	logic [SUM_W-1:0]            q0_s3 [gri_pkg::NUM_AXES];
	logic [SUM_W-1:0]            mag_s3 [gri_pkg::NUM_AXES];
	logic [gri_pkg::NUM_AXES-1:0] neg_s3;
	logic                        done_s3;

	logic [PROD_W-1:0]           prod [gri_pkg::NUM_AXES];
	logic [SUM_W-1:0]            qn [gri_pkg::NUM_AXES];
	logic [SUM_W-1:0]            rem [gri_pkg::NUM_AXES];
	logic [SUM_W-1:0]            quot [gri_pkg::NUM_AXES];
	logic signed [SUM_W:0]       squot [gri_pkg::NUM_AXES];
	gri_pkg::rate_t              bias_new [gri_pkg::NUM_AXES];
	gri_pkg::rate_t              bias_q [gri_pkg::NUM_AXES];

	always_comb begin
		for (int a = 0; a < gri_pkg::NUM_AXES; a++) begin
			prod[a]     = PROD_W'(mag_s2[a]) * PROD_W'(RECIP);
			qn[a]       = q0_s3[a] * N_SUM;
			rem[a]      = mag_s3[a] - qn[a];
			quot[a]     = q0_s3[a] + SUM_W'(rem[a] >= N_SUM);
			squot[a]    = neg_s3[a] ? -$signed({1'b0, quot[a]}) : $signed({1'b0, quot[a]});
			bias_new[a] = squot[a][gri_pkg::RATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			if (ctl.load2) begin
				done_s2 <= cal.done & ctl.step1;
			end
			if (ctl.load3) begin
				done_s3 <= done_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load2) begin
			mag_s2 <= mag;
			neg_s2 <= cal.neg;
		end
		if (ctl.load3) begin
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			for (int a = 0; a < gri_pkg::NUM_AXES; a++) begin
				q0_s3[a] <= prod[a][PROD_W-2:SUM_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q[gri_pkg::AXIS_YAW]   <= gri_pkg::YAW_BIAS_RESET;
			bias_q[gri_pkg::AXIS_PITCH] <= gri_pkg::PITCH_BIAS_RESET;
			bias_q[gri_pkg::AXIS_ROLL]  <= gri_pkg::ROLL_BIAS_RESET;
		end else if (ctl.step3 && done_s3) begin
			bias_q <= bias_new;
		end
	end

	assign bias = bias_q;

endmodule

`default_nettype wire

// ===== sv/gri_axis.sv =====
// gri_axis: one axis datapath: bias correction, deadband and rate*ms (stage 4),
// angle accumulate, pose reset and wrap to (-180, 180] deg (stage 5). Uses gri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gri_axis (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gri_pkg::pipe_ctl_t  ctl,
	input  wire gri_pkg::rate_t      rate,
	input  wire gri_pkg::rate_t      bias,
	input  wire gri_pkg::deadband_t  deadband,
	input  wire gri_pkg::ms_t        ms,
	input  wire logic                rst_pose,
	output gri_pkg::angle_t          angle_next
);

	localparam gri_pkg::acc_t WRAP_HI2 = gri_pkg::HALF_TURN + gri_pkg::FULL_TURN;
	localparam gri_pkg::acc_t WRAP_LO2 = -gri_pkg::HALF_TURN - gri_pkg::FULL_TURN;
	localparam gri_pkg::acc_t TWO_TURNS = gri_pkg::FULL_TURN + gri_pkg::FULL_TURN;

	logic signed [gri_pkg::CORR_W-1:0] corr;
	logic [gri_pkg::CORR_W-1:0]        corr_mag;
	logic signed [gri_pkg::MS_W:0]     ms_sg;
	gri_pkg::acc_t                     inc;
	gri_pkg::acc_t                     inc_s5;
	gri_pkg::acc_t                     acc;
	gri_pkg::acc_t                     wrapped;
	gri_pkg::angle_t                   total_q;

	assign corr     = gri_pkg::CORR_W'(rate) - gri_pkg::CORR_W'(bias);
	assign corr_mag = corr[gri_pkg::CORR_W-1] ? gri_pkg::CORR_W'(-corr) : gri_pkg::CORR_W'(corr);
	assign ms_sg    = $signed({1'b0, ms});
	assign inc      = gri_pkg::ACC_W'(corr) * gri_pkg::ACC_W'(ms_sg);

	always_ff @(posedge clk) begin
		if (ctl.load5) begin
			inc_s5 <= (corr_mag > {2'b00, deadband}) ? inc : '0;
		end
	end

	assign acc = gri_pkg::ACC_W'(total_q) + inc_s5;

	// one increment can span up to two turns
	always_comb begin
		priority if (acc > WRAP_HI2) begin
			wrapped = acc - TWO_TURNS;
		end else if (acc > gri_pkg::HALF_TURN) begin
			wrapped = acc - gri_pkg::FULL_TURN;
		end else if (acc <= WRAP_LO2) begin
			wrapped = acc + TWO_TURNS;
		end else if (acc <= -gri_pkg::HALF_TURN) begin
			wrapped = acc + gri_pkg::FULL_TURN;
		end else begin
			wrapped = acc;
		end
	end

	assign angle_next = rst_pose ? '0 : wrapped[gri_pkg::ANGLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctl.step5) begin
			total_q <= angle_next;
		end
	end

endmodule

`default_nettype wire

// ===== sv/gyro_rate_integrator.sv =====
// gyro_rate_integrator: top level; stream ports, pipeline control and output register.
// Instantiates gri_calib, gri_bias_div and gri_axis; uses gri_pkg.
//
// Usage: each s_* transaction carries one gyro sample (three raw rates in 1/16 deg/s,
// elapsed ms, pose-reset and calibration-start requests) and yields exactly one
// m_* transaction with the three wrapped angles (1/16000 deg) and the calibration
// busy flag. The deadband register is written over cfg_valid/cfg_data (cfg_ready is
// always high); the user must do so only while no sample is in flight (not enforced).
// Pipeline: a sample passes through the input register, calibration sum, reciprocal
// multiply, divide correction plus bias write, rate*ms product, and angle accumulate
// into the output register, in that order. Throughput: one sample per cycle unless
// m_tready stalls the output; the angle registers close their loop combinationally,
// and a finished calibration's bias is ready for the very next sample.
// Reset: angles and sums clear, biases and deadband take their default values.
// Stall: when m_tready is low the result is held; stages behind it keep filling
// bubbles, and s_tready drops only once every stage holds a sample.
`timescale 1ns / 1ps
`default_nettype none

module gyro_rate_integrator #(
	parameter int CALIB_SAMPLES = 100
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tdata: yaw_rate[15:0], pitch_rate[31:16], roll_rate[47:32], elapsed_ms[54:48],
	//          reset_pose[55], start_calibration[56], zero [63:57]
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [gri_pkg::IN_DATA_W-1:0]   s_tdata,
	// m_tdata: yaw_angle_out[22:0], pitch_angle_out[45:23], roll_angle_out[68:46],
	//          calibration_busy[69], zero [71:70]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [gri_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [gri_pkg::DB_W-1:0]        cfg_data
);

	localparam int SUM_W = gri_pkg::RATE_W + $clog2(CALIB_SAMPLES);
	localparam int NA    = gri_pkg::NUM_AXES;

	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic out_valid_q;
	logic [gri_pkg::OUT_DATA_W-1:0] out_data_q;

	gri_pkg::rate_t rate_in [NA];
	gri_pkg::rate_t rate_s1 [NA];
	gri_pkg::rate_t rate_s2 [NA];
	gri_pkg::rate_t rate_s3 [NA];
	gri_pkg::rate_t rate_s4 [NA];
	gri_pkg::ms_t   ms_s1, ms_s2, ms_s3, ms_s4;
	logic           rst_s1, rst_s2, rst_s3, rst_s4, rst_s5;
	logic           start_s1;
	logic           busy_s2, busy_s3, busy_s4, busy_s5;

	gri_pkg::deadband_t  deadband_q;
	gri_pkg::pipe_ctl_t  ctl;
	gri_pkg::calib_ctl_t cal;
	logic [SUM_W-1:0]    cal_mag [NA];
	gri_pkg::rate_t      bias [NA];
	gri_pkg::angle_t     angle_next [NA];

	// a stage takes a new sample when it is empty or its sample moves on
	assign rdy_o = ~out_valid_q | m_tready;
	assign rdy5  = ~valid_s5 | rdy_o;
	assign rdy4  = ~valid_s4 | rdy5;
	assign rdy3  = ~valid_s3 | rdy4;
	assign rdy2  = ~valid_s2 | rdy3;
	assign rdy1  = ~valid_s1 | rdy2;

	assign s_tready  = rdy1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign cfg_ready = 1'b1;

	assign ctl.step1 = valid_s1 & rdy2;
	assign ctl.load2 = rdy2;
	assign ctl.load3 = rdy3;
	assign ctl.step3 = valid_s3 & rdy4;
	assign ctl.load5 = rdy5;
	assign ctl.step5 = valid_s5 & rdy_o;

	assign rate_in[gri_pkg::AXIS_YAW]   = s_tdata[15:0];
	assign rate_in[gri_pkg::AXIS_PITCH] = s_tdata[31:16];
	assign rate_in[gri_pkg::AXIS_ROLL]  = s_tdata[47:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= gri_pkg::DEADBAND_RESET;
		end else if (cfg_valid) begin
			deadband_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy_o) out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			rate_s1  <= rate_in;
			ms_s1    <= s_tdata[54:48];
			rst_s1   <= s_tdata[55];
			start_s1 <= s_tdata[56];
		end
		if (rdy2) begin
			rate_s2 <= rate_s1;
			ms_s2   <= (ms_s1 > gri_pkg::MAX_MS) ? gri_pkg::MAX_MS : ms_s1;
			rst_s2  <= rst_s1;
			busy_s2 <= cal.busy;
		end
		if (rdy3) begin
			rate_s3 <= rate_s2;
			ms_s3   <= ms_s2;
			rst_s3  <= rst_s2;
			busy_s3 <= busy_s2;
		end
		if (rdy4) begin
			rate_s4 <= rate_s3;
			ms_s4   <= ms_s3;
			rst_s4  <= rst_s3;
			busy_s4 <= busy_s3;
		end
		if (rdy5) begin
			rst_s5  <= rst_s4;
			busy_s5 <= busy_s4;
		end
		if (rdy_o) begin
			out_data_q <= {2'b00, busy_s5, angle_next[gri_pkg::AXIS_ROLL],
				angle_next[gri_pkg::AXIS_PITCH], angle_next[gri_pkg::AXIS_YAW]};
		end
	end

	gri_calib #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_calib (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rate   (rate_s1),
		.start  (start_s1),
		.cal    (cal),
		.mag    (cal_mag)
	);

	gri_bias_div #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_bias_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cal    (cal),
		.mag    (cal_mag),
		.bias   (bias)
	);

	for (genvar a = 0; a < NA; a++) begin : g_axis
		gri_axis u_axis (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.rate       (rate_s4[a]),
			.bias       (bias[a]),
			.deadband   (deadband_q),
			.ms         (ms_s4),
			.rst_pose   (rst_s5),
			.angle_next (angle_next[a])
		);
	end

	gri_pkg::angle_t chk_yaw, chk_pitch, chk_roll;
	assign chk_yaw   = out_data_q[22:0];
	assign chk_pitch = out_data_q[45:23];
	assign chk_roll  = out_data_q[68:46];

	// with the output register empty the whole pipeline must be able to take a sample
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("s_tready low with empty output register");

	a_out_from_stage5: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s5))
		else $error("result appeared without a sample in the last stage");

	a_yaw_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (chk_yaw <= gri_pkg::HALF_TURN && chk_yaw > -gri_pkg::HALF_TURN))
		else $error("yaw angle outside half turn");

	a_pitch_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (chk_pitch <= gri_pkg::HALF_TURN && chk_pitch > -gri_pkg::HALF_TURN))
		else $error("pitch angle outside half turn");

	a_roll_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (chk_roll <= gri_pkg::HALF_TURN && chk_roll > -gri_pkg::HALF_TURN))
		else $error("roll angle outside half turn");

endmodule

`default_nettype wire
